[design/interval_reservation_table_core_macros.svh]
// assertion macros for the interval reservation table core
// used by the controller and datapath files; expects clk and rst_n in scope
`ifndef INTERVAL_RESERVATION_TABLE_CORE_MACROS_SVH
`define INTERVAL_RESERVATION_TABLE_CORE_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define IRT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("irt assertion failed (same cycle)");

// next-cycle implication
`define IRT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("irt assertion failed (next cycle)");

`else

`define IRT_ASSERT_IMP(lbl, ante, cons)
`define IRT_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

[design/irt_pkg.sv]
// shared types and constants for the interval reservation table core
// no dependencies
package irt_pkg;

  localparam int FIELD_WIDTH  = 16;
  localparam int MAX_RESULTS  = 16;
  localparam int RESULT_CNT_W = $clog2(MAX_RESULTS);

  // operation codes
  localparam logic [2:0] OP_RESERVE = 3'd0;
  localparam logic [2:0] OP_RELEASE = 3'd1;
  localparam logic [2:0] OP_CHECK   = 3'd2;
  localparam logic [2:0] OP_LIST    = 3'd3;
  localparam logic [2:0] OP_MERGE   = 3'd4;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  typedef struct packed {
    logic [2:0]             operation;
    logic [FIELD_WIDTH-1:0] range_start;
    logic [FIELD_WIDTH-1:0] range_end;
  } in_req_t;

  typedef struct packed {
    logic [1:0]             status;
    logic                   available;
    logic                   entry_valid;
    logic [FIELD_WIDTH-1:0] out_start;
    logic [FIELD_WIDTH-1:0] out_end;
    logic                   last_item;
  } out_rsp_t;

  typedef enum logic [2:0] {
    WALK_PROBE,
    WALK_DROP,
    WALK_INSERT,
    WALK_LIST,
    WALK_MERGE
  } walk_e_t;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_PROBE,
    CS_UPDATE,
    CS_LIST,
    CS_REPLY
  } ctrl_state_t;

  typedef struct packed {
    logic       capture;
    logic       start;
    walk_e_t    mode;
    logic       reply;
    logic [1:0] reply_status;
    logic       reply_avail;
  } irt_cmd_t;

  typedef struct packed {
    logic bad_range;
    logic full;
    logic empty;
    logic walk_done;
    logic hit;
    logic out_free;
  } irt_sts_t;

endpackage

[design/irt_datapath.sv]
// table memory, walk engine, merge accumulator and result register
// depends on irt_pkg and the assertion macro header
`include "interval_reservation_table_core_macros.svh"

module irt_datapath import irt_pkg::*; #(
  parameter int TABLE_DEPTH = 16,
  parameter int COORD_WIDTH = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  in_req_t  in_req,
  input  irt_cmd_t cmd,
  output irt_sts_t sts,
  output logic     out_valid,
  input  logic     out_ready,
  output out_rsp_t out_rsp
);

  localparam int CW    = (COORD_WIDTH < FIELD_WIDTH) ? COORD_WIDTH : FIELD_WIDTH;
  localparam int AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  logic [CW-1:0] mem_s [TABLE_DEPTH];
  logic [CW-1:0] mem_e [TABLE_DEPTH];

  logic [CW-1:0] req_s, req_e;

  // control registers
  logic                    walking_r, walking_nxt;
  walk_e_t                 mode_r, mode_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [CNT_W-1:0]        rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]        wr_ptr_r, wr_ptr_nxt;
  logic                    rd_vld_r, rd_vld_nxt;
  logic                    hit_r, hit_nxt;
  logic                    placed_r, placed_nxt;
  logic                    pend_vld_r, pend_vld_nxt;
  logic                    acc_vld_r, acc_vld_nxt;
  logic [RESULT_CNT_W-1:0] n_r, n_nxt;
  logic                    stop_r, stop_nxt;
  logic                    out_valid_r, out_valid_nxt;

  // payload registers
  logic [CW-1:0] s_r, s_nxt, e_r, e_nxt;
  logic [CW-1:0] pend_s_r, pend_s_nxt, pend_e_r, pend_e_nxt;
  logic [CW-1:0] acc_s_r, acc_s_nxt, acc_e_r, acc_e_nxt;
  logic [CW-1:0] rd_s_r, rd_e_r;
  out_rsp_t      out_rsp_r, out_rsp_nxt;

  logic          more_rd, out_free, x_hit, new_first, joins, n_last;
  logic          consume, rd_en, out_load, finish;
  logic          mem_we;
  logic [CW-1:0] wdata_s, wdata_e;

  assign req_s = in_req.range_start[CW-1:0];
  assign req_e = in_req.range_end[CW-1:0];

  assign more_rd   = rd_ptr_r < cnt_r;
  assign out_free  = !out_valid_r || out_ready;
  assign x_hit     = (s_r < rd_e_r) && (e_r > rd_s_r);
  assign new_first = (rd_s_r > s_r) || ((rd_s_r == s_r) && (rd_e_r > e_r));
  assign joins     = rd_s_r <= acc_e_r;
  assign n_last    = n_r == RESULT_CNT_W'(MAX_RESULTS - 1);

  always_comb begin
    walking_nxt  = walking_r;
    mode_nxt     = mode_r;
    cnt_nxt      = cnt_r;
    rd_ptr_nxt   = rd_ptr_r;
    wr_ptr_nxt   = wr_ptr_r;
    rd_vld_nxt   = rd_vld_r;
    hit_nxt      = hit_r;
    placed_nxt   = placed_r;
    pend_vld_nxt = pend_vld_r;
    acc_vld_nxt  = acc_vld_r;
    n_nxt        = n_r;
    stop_nxt     = stop_r;
    s_nxt        = s_r;
    e_nxt        = e_r;
    pend_s_nxt   = pend_s_r;
    pend_e_nxt   = pend_e_r;
    acc_s_nxt    = acc_s_r;
    acc_e_nxt    = acc_e_r;
    out_rsp_nxt  = out_rsp_r;
    consume      = 1'b0;
    out_load     = 1'b0;
    finish       = 1'b0;
    mem_we       = 1'b0;
    wdata_s      = rd_s_r;
    wdata_e      = rd_e_r;

    // one stored entry per cycle, unless a list or merge result waits for the output
    if (walking_r && !stop_r && rd_vld_r) begin
      case (mode_r) inside
        WALK_DROP, WALK_INSERT: begin
          consume = 1'b1;
          if (x_hit) begin
            hit_nxt = 1'b1;
          end else begin
            mem_we     = 1'b1;
            wr_ptr_nxt = wr_ptr_r + CNT_W'(1);
            // one-entry carry keeps writes at or below the read position
            if (mode_r == WALK_INSERT && !placed_r && new_first) begin
              wdata_s      = s_r;
              wdata_e      = e_r;
              placed_nxt   = 1'b1;
              pend_vld_nxt = 1'b1;
              pend_s_nxt   = rd_s_r;
              pend_e_nxt   = rd_e_r;
            end else if (pend_vld_r) begin
              wdata_s    = pend_s_r;
              wdata_e    = pend_e_r;
              pend_s_nxt = rd_s_r;
              pend_e_nxt = rd_e_r;
            end
          end
        end
        WALK_LIST: begin
          if (out_free) begin
            consume                 = 1'b1;
            out_load                = 1'b1;
            out_rsp_nxt             = '0;
            out_rsp_nxt.status      = ST_OK;
            out_rsp_nxt.entry_valid = 1'b1;
            out_rsp_nxt.out_start   = FIELD_WIDTH'(rd_s_r);
            out_rsp_nxt.out_end     = FIELD_WIDTH'(rd_e_r);
            out_rsp_nxt.last_item   = !more_rd || n_last;
            n_nxt                   = n_r + RESULT_CNT_W'(1);
            if (n_last) begin
              stop_nxt = 1'b1;
            end
          end
        end
        WALK_MERGE: begin
          if (!acc_vld_r) begin
            consume     = 1'b1;
            acc_vld_nxt = 1'b1;
            acc_s_nxt   = rd_s_r;
            acc_e_nxt   = rd_e_r;
          end else if (joins) begin
            consume = 1'b1;
            if (rd_e_r > acc_e_r) begin
              acc_e_nxt = rd_e_r;
            end
          end else if (out_free) begin
            // gap: send the union built so far
            consume                 = 1'b1;
            out_load                = 1'b1;
            out_rsp_nxt             = '0;
            out_rsp_nxt.status      = ST_OK;
            out_rsp_nxt.entry_valid = 1'b1;
            out_rsp_nxt.out_start   = FIELD_WIDTH'(acc_s_r);
            out_rsp_nxt.out_end     = FIELD_WIDTH'(acc_e_r);
            out_rsp_nxt.last_item   = n_last;
            n_nxt                   = n_r + RESULT_CNT_W'(1);
            acc_s_nxt               = rd_s_r;
            acc_e_nxt               = rd_e_r;
            if (n_last) begin
              stop_nxt = 1'b1;
            end
          end
        end
        default: begin
          consume = 1'b1;
          if (x_hit) begin
            hit_nxt = 1'b1;
          end
        end
      endcase
    end

    rd_en = walking_r && !stop_r && more_rd && (!rd_vld_r || consume);
    if (rd_en) begin
      rd_vld_nxt = 1'b1;
      rd_ptr_nxt = rd_ptr_r + CNT_W'(1);
    end else if (consume) begin
      rd_vld_nxt = 1'b0;
    end

    // end of walk
    if (walking_r && (stop_r || (!more_rd && !rd_vld_r))) begin
      case (mode_r)
        WALK_DROP: begin
          finish  = 1'b1;
          cnt_nxt = wr_ptr_r;
        end
        WALK_INSERT: begin
          finish  = 1'b1;
          mem_we  = 1'b1;
          wdata_s = pend_vld_r ? pend_s_r : s_r;
          wdata_e = pend_vld_r ? pend_e_r : e_r;
          cnt_nxt = wr_ptr_r + CNT_W'(1);
        end
        WALK_MERGE: begin
          if (stop_r) begin
            finish = 1'b1;
          end else if (out_free) begin
            finish                  = 1'b1;
            out_load                = 1'b1;
            out_rsp_nxt             = '0;
            out_rsp_nxt.status      = ST_OK;
            out_rsp_nxt.entry_valid = 1'b1;
            out_rsp_nxt.out_start   = FIELD_WIDTH'(acc_s_r);
            out_rsp_nxt.out_end     = FIELD_WIDTH'(acc_e_r);
            out_rsp_nxt.last_item   = 1'b1;
          end
        end
        default: begin
          finish = 1'b1;
        end
      endcase
      if (finish) begin
        walking_nxt = 1'b0;
        rd_vld_nxt  = 1'b0;
        stop_nxt    = 1'b0;
      end
    end

    if (cmd.reply) begin
      out_load              = 1'b1;
      out_rsp_nxt           = '0;
      out_rsp_nxt.status    = cmd.reply_status;
      out_rsp_nxt.available = cmd.reply_avail;
      out_rsp_nxt.last_item = 1'b1;
    end

    if (cmd.capture) begin
      s_nxt = req_s;
      e_nxt = req_e;
    end

    // a new walk overrides the end of the previous one
    if (cmd.start) begin
      walking_nxt  = 1'b1;
      mode_nxt     = cmd.mode;
      rd_ptr_nxt   = '0;
      wr_ptr_nxt   = '0;
      rd_vld_nxt   = 1'b0;
      hit_nxt      = 1'b0;
      placed_nxt   = 1'b0;
      pend_vld_nxt = 1'b0;
      acc_vld_nxt  = 1'b0;
      n_nxt        = '0;
      stop_nxt     = 1'b0;
    end

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      walking_r   <= 1'b0;
      mode_r      <= WALK_PROBE;
      cnt_r       <= '0;
      rd_ptr_r    <= '0;
      wr_ptr_r    <= '0;
      rd_vld_r    <= 1'b0;
      hit_r       <= 1'b0;
      placed_r    <= 1'b0;
      pend_vld_r  <= 1'b0;
      acc_vld_r   <= 1'b0;
      n_r         <= '0;
      stop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      walking_r   <= walking_nxt;
      mode_r      <= mode_nxt;
      cnt_r       <= cnt_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      rd_vld_r    <= rd_vld_nxt;
      hit_r       <= hit_nxt;
      placed_r    <= placed_nxt;
      pend_vld_r  <= pend_vld_nxt;
      acc_vld_r   <= acc_vld_nxt;
      n_r         <= n_nxt;
      stop_r      <= stop_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s_r       <= s_nxt;
    e_r       <= e_nxt;
    pend_s_r  <= pend_s_nxt;
    pend_e_r  <= pend_e_nxt;
    acc_s_r   <= acc_s_nxt;
    acc_e_r   <= acc_e_nxt;
    out_rsp_r <= out_rsp_nxt;
  end

  // interval store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_s[wr_ptr_r[AW-1:0]] <= wdata_s;
      mem_e[wr_ptr_r[AW-1:0]] <= wdata_e;
    end
    if (rd_en) begin
      rd_s_r <= mem_s[rd_ptr_r[AW-1:0]];
      rd_e_r <= mem_e[rd_ptr_r[AW-1:0]];
    end
  end

  assign sts.bad_range = req_s >= req_e;
  assign sts.full      = cnt_r == CNT_W'(TABLE_DEPTH);
  assign sts.empty     = cnt_r == '0;
  assign sts.walk_done = finish;
  assign sts.hit       = hit_r;
  assign sts.out_free  = out_free;

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  `IRT_ASSERT_IMP(a_wr_behind_rd, walking_r, wr_ptr_r <= rd_ptr_r)
  `IRT_ASSERT_IMP(a_cnt_in_range, 1'b1, cnt_r <= CNT_W'(TABLE_DEPTH))
  `IRT_ASSERT_IMP(a_rd_only_in_walk, rd_vld_r, walking_r)
  `IRT_ASSERT_IMP(a_load_slot_free, out_load, out_free)

endmodule

[design/irt_ctrl.sv]
// controller state machine: decodes requests and sequences table walks
// depends on irt_pkg and the assertion macro header
`include "interval_reservation_table_core_macros.svh"

module irt_ctrl import irt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_op,
  input  irt_sts_t   sts,
  output irt_cmd_t   cmd
);

  ctrl_state_t state_r, state_nxt;
  logic [2:0]  op_r, op_nxt;
  logic [1:0]  rep_status_r, rep_status_nxt;
  logic        rep_avail_r, rep_avail_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    rep_status_r <= rep_status_nxt;
    rep_avail_r  <= rep_avail_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    rep_status_nxt = rep_status_r;
    rep_avail_nxt  = rep_avail_r;
    in_ready       = 1'b0;
    cmd            = '0;
    cmd.mode       = WALK_PROBE;

    unique case (state_r)
      CS_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture    = 1'b1;
          op_nxt         = in_op;
          rep_status_nxt = ST_OK;
          rep_avail_nxt  = 1'b0;
          unique case (in_op) inside
            OP_RESERVE, OP_RELEASE, OP_CHECK: begin
              if (sts.bad_range) begin
                rep_status_nxt = ST_BAD_RANGE;
                state_nxt      = CS_REPLY;
              end else if (in_op == OP_CHECK) begin
                cmd.start = 1'b1;
                cmd.mode  = WALK_PROBE;
                state_nxt = CS_PROBE;
              end else if (in_op == OP_RELEASE) begin
                cmd.start = 1'b1;
                cmd.mode  = WALK_DROP;
                state_nxt = CS_UPDATE;
              end else if (sts.full) begin
                // full table: only a reserve that frees a slot may insert
                cmd.start = 1'b1;
                cmd.mode  = WALK_PROBE;
                state_nxt = CS_PROBE;
              end else begin
                cmd.start = 1'b1;
                cmd.mode  = WALK_INSERT;
                state_nxt = CS_UPDATE;
              end
            end
            OP_LIST, OP_MERGE: begin
              if (sts.empty) begin
                state_nxt = CS_REPLY;
              end else begin
                cmd.start = 1'b1;
                cmd.mode  = (in_op == OP_LIST) ? WALK_LIST : WALK_MERGE;
                state_nxt = CS_LIST;
              end
            end
            default: begin
              state_nxt = CS_REPLY;
            end
          endcase
        end
      end
      CS_PROBE: begin
        if (sts.walk_done) begin
          if (op_r == OP_CHECK) begin
            rep_avail_nxt = !sts.hit;
            state_nxt     = CS_REPLY;
          end else if (sts.hit) begin
            cmd.start = 1'b1;
            cmd.mode  = WALK_INSERT;
            state_nxt = CS_UPDATE;
          end else begin
            rep_status_nxt = ST_FULL;
            state_nxt      = CS_REPLY;
          end
        end
      end
      CS_UPDATE: begin
        if (sts.walk_done) begin
          state_nxt = CS_REPLY;
        end
      end
      CS_LIST: begin
        if (sts.walk_done) begin
          state_nxt = CS_IDLE;
        end
      end
      CS_REPLY: begin
        if (sts.out_free) begin
          cmd.reply        = 1'b1;
          cmd.reply_status = rep_status_r;
          cmd.reply_avail  = rep_avail_r;
          state_nxt        = CS_IDLE;
        end
      end
      default: begin
        state_nxt = CS_IDLE;
      end
    endcase
  end

  `IRT_ASSERT_IMP(a_done_while_walking, sts.walk_done,
                  state_r == CS_PROBE || state_r == CS_UPDATE || state_r == CS_LIST)
  `IRT_ASSERT_IMP(a_reply_slot_free, cmd.reply, sts.out_free)
  `IRT_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

endmodule

[design/interval_reservation_table_core.sv]
// Interval reservation table. Holds up to TABLE_DEPTH half-open intervals
// [start,end) sorted by start then end, in a single-port-write, single-port-read
// memory. Reserve drops every stored interval that overlaps the request and
// inserts it in order (status full if nothing could be dropped from a full
// table); release drops overlaps; check reports whether nothing overlaps; the
// two list requests stream the stored intervals or their unions (touching ones
// merge), at most 16 results; list results go out one per cycle while the output
// is taken. Requests are handled one at a time. Each walk reads one memory entry
// per cycle while the output does not hold it; a reserve on a full table first
// walks to probe for overlaps, then again to insert if one is found. No clearing
// pass is needed after reset. Coordinates are masked to COORD_WIDTH bits (up to 16).
// depends on irt_pkg, irt_ctrl and irt_datapath

module interval_reservation_table_core import irt_pkg::*; #(
  parameter int TABLE_DEPTH = 16,
  parameter int COORD_WIDTH = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_req_t  in_req,
  output logic     out_valid,
  input  logic     out_ready,
  output out_rsp_t out_rsp
);

  irt_cmd_t cmd;
  irt_sts_t sts;

  irt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_op    (in_req.operation),
    .sts      (sts),
    .cmd      (cmd)
  );

  irt_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .COORD_WIDTH (COORD_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_rsp   (out_rsp)
  );

endmodule

[tb/tb_interval_reservation_table_core.sv]
// testbench for interval_reservation_table_core: directed and random requests with
// a table predictor, random idling on both channels, field-by-field result checks
// depends on irt_pkg and the interval_reservation_table_core rtl
module tb_interval_reservation_table_core;
  import irt_pkg::*;

  localparam int TBL_DEPTH   = 16;
  localparam int IDLE_LIMIT  = 4000;
  localparam int SETTLE_CYCS = 64;

  typedef struct {
    in_req_t req;
    bit      hold_for_drain;
  } stim_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  in_req_t  in_req = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  out_rsp_t out_rsp;

  stim_t       pend_q[$];
  out_rsp_t    want_rsp_q[$];
  logic [15:0] resv_start[TBL_DEPTH];
  logic [15:0] resv_end[TBL_DEPTH];
  int          resv_count = 0;
  int          err_cnt = 0;
  int          sender_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          idle_cycles = 0;

  interval_reservation_table_core #(
    .TABLE_DEPTH(TBL_DEPTH),
    .COORD_WIDTH(16)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_rsp  (out_rsp)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic bit overlaps_entry(int idx, logic [15:0] s, logic [15:0] e);
    return s < resv_end[idx] && e > resv_start[idx];
  endfunction

  // updates the shadow table and queues the replies one request causes
  function automatic void predict_table_reply(in_req_t r);
    logic [15:0] s;
    logic [15:0] e;
    logic [15:0] cs;
    logic [15:0] ce;
    out_rsp_t    rsp;
    out_rsp_t    burst[MAX_RESULTS];
    int          n;
    int          w;
    int          pos;
    s = r.range_start;
    e = r.range_end;
    rsp = '0;
    rsp.last_item = 1'b1;
    n = 0;
    if (r.operation <= OP_CHECK) begin
      if (s >= e) begin
        rsp.status = ST_BAD_RANGE;
      end else if (r.operation == OP_CHECK) begin
        rsp.available = 1'b1;
        for (int i = 0; i < resv_count; i++)
          if (overlaps_entry(i, s, e)) rsp.available = 1'b0;
      end else begin
        w = 0;
        for (int i = 0; i < resv_count; i++) begin
          if (!overlaps_entry(i, s, e)) begin
            resv_start[w] = resv_start[i];
            resv_end[w] = resv_end[i];
            w++;
          end
        end
        resv_count = w;
        if (r.operation == OP_RESERVE) begin
          if (resv_count >= TBL_DEPTH) begin
            rsp.status = ST_FULL;
          end else begin
            pos = 0;
            while (pos < resv_count && (resv_start[pos] < s ||
                   (resv_start[pos] == s && resv_end[pos] <= e)))
              pos++;
            for (int i = resv_count; i > pos; i--) begin
              resv_start[i] = resv_start[i-1];
              resv_end[i] = resv_end[i-1];
            end
            resv_start[pos] = s;
            resv_end[pos] = e;
            resv_count++;
          end
        end
      end
      want_rsp_q.insert(want_rsp_q.size(), rsp);
    end else if ((r.operation == OP_LIST || r.operation == OP_MERGE) && resv_count > 0) begin
      rsp = '0;
      rsp.entry_valid = 1'b1;
      if (r.operation == OP_LIST) begin
        for (int i = 0; i < resv_count && n < MAX_RESULTS; i++) begin
          burst[n] = rsp;
          burst[n].out_start = resv_start[i];
          burst[n].out_end = resv_end[i];
          n++;
        end
      end else begin
        cs = resv_start[0];
        ce = resv_end[0];
        for (int i = 1; i < resv_count && n < MAX_RESULTS; i++) begin
          // touching intervals join the running union as well
          if (resv_start[i] <= ce) begin
            if (resv_end[i] > ce) ce = resv_end[i];
          end else begin
            burst[n] = rsp;
            burst[n].out_start = cs;
            burst[n].out_end = ce;
            n++;
            cs = resv_start[i];
            ce = resv_end[i];
          end
        end
        if (n < MAX_RESULTS) begin
          burst[n] = rsp;
          burst[n].out_start = cs;
          burst[n].out_end = ce;
          n++;
        end
      end
      for (int i = 0; i < n; i++) begin
        rsp = burst[i];
        rsp.last_item = (i == n - 1);
        want_rsp_q.insert(want_rsp_q.size(), rsp);
      end
    end else begin
      // empty list or unknown operation
      want_rsp_q.insert(want_rsp_q.size(), rsp);
    end
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      err_cnt++;
    end
  endfunction

  // driver
  always @(posedge clk) begin
    stim_t nxt;
    bit    go;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_req <= '0;
    end else begin
      if (in_valid && in_ready) predict_table_reply(in_req);
      if (!in_valid || in_ready) begin
        go = pend_q.size() > 0;
        if (go && pend_q[0].hold_for_drain && want_rsp_q.size() > 0) go = 1'b0;
        if (go && $urandom_range(99) < sender_idle_pct) go = 1'b0;
        if (go) begin
          nxt = pend_q.pop_front();
          in_valid <= 1'b1;
          in_req <= nxt.req;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    out_rsp_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (want_rsp_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual %h", $time, out_rsp);
          err_cnt++;
        end else begin
          want = want_rsp_q.pop_front();
          check_field("status", 16'(want.status), 16'(out_rsp.status));
          check_field("available", 16'(want.available), 16'(out_rsp.available));
          check_field("entry_valid", 16'(want.entry_valid), 16'(out_rsp.entry_valid));
          check_field("out_start", want.out_start, out_rsp.out_start);
          check_field("out_end", want.out_end, out_rsp.out_end);
          check_field("last_item", 16'(want.last_item), 16'(out_rsp.last_item));
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic add_request(logic [2:0] op, logic [15:0] s, logic [15:0] e,
                             bit hold = 1'b0);
    stim_t st;
    st.req.operation = op;
    st.req.range_start = s;
    st.req.range_end = e;
    st.hold_for_drain = hold;
    pend_q.insert(pend_q.size(), st);
  endtask

  task automatic add_random_request();
    int          pick;
    int          op_pick;
    logic [2:0]  op;
    logic [15:0] s;
    logic [15:0] e;
    pick = $urandom_range(99);
    if (pick < 8) begin
      // noise over the full field ranges, unknown operations included
      op = 3'($urandom_range(7));
      s = 16'($urandom);
      e = 16'($urandom);
    end else if (pick < 14) begin
      op = ($urandom_range(2) == 0) ? OP_RESERVE :
           ($urandom_range(1) == 0) ? OP_RELEASE : OP_CHECK;
      e = 16'($urandom_range(511));
      s = e + 16'($urandom_range(3));
      if (s < e) s = e;
    end else begin
      op_pick = $urandom_range(99);
      if (op_pick < 40) op = OP_RESERVE;
      else if (op_pick < 52) op = OP_RELEASE;
      else if (op_pick < 72) op = OP_CHECK;
      else if (op_pick < 86) op = OP_LIST;
      else op = OP_MERGE;
      // small coordinates on a coarse grid so neighbors often touch
      s = 16'($urandom_range(63) * 8);
      if ($urandom_range(1) == 0) s = s + 16'($urandom_range(7));
      e = s + 16'((op == OP_RESERVE) ? $urandom_range(1, 24) : $urandom_range(1, 40));
    end
    add_request(op, s, e, $urandom_range(99) < 3);
  endtask

  task automatic wait_all_done();
    while (pend_q.size() > 0 || in_valid || want_rsp_q.size() > 0) @(posedge clk);
  endtask

  initial begin
    int idle_plan[4];
    int stall_plan[4];
    idle_plan = '{0, 59, 0, 18};
    stall_plan = '{0, 0, 59, 18};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    add_request(OP_LIST, 16'hFFFF, 16'hFFFF);
    add_request(OP_MERGE, 16'h0000, 16'h0000);
    add_request(OP_RESERVE, 16'h0000, 16'hFFFF);
    add_request(OP_CHECK, 16'hFFFF, 16'hFFFF);
    add_request(OP_RELEASE, 16'hFFFF, 16'h0000);
    add_request(OP_RESERVE, 16'd7, 16'd7);
    add_request(OP_CHECK, 16'd0, 16'd1);
    add_request(3'd7, 16'hFFFF, 16'hFFFF);
    add_request(OP_RESERVE, 16'hFFFE, 16'hFFFF);
    // fill the table with touching neighbors, then overflow it
    for (int i = 0; i < TBL_DEPTH - 1; i++)
      add_request(OP_RESERVE, 16'(i * 8), 16'(i * 8 + 8));
    add_request(OP_RESERVE, 16'd200, 16'd210);
    add_request(OP_LIST, 16'd0, 16'd0, 1'b1);
    add_request(OP_MERGE, 16'd0, 16'd0);
    add_request(OP_RELEASE, 16'h0000, 16'hFFFF);
    wait_all_done();

    for (int p = 0; p < 4; p++) begin
      sender_idle_pct = idle_plan[p];
      recv_stall_pct = stall_plan[p];
      repeat (125) add_random_request();
      wait_all_done();
    end

    repeat (SETTLE_CYCS) @(posedge clk);
    if (err_cnt == 0 && want_rsp_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+design
design/irt_pkg.sv
design/irt_datapath.sv
design/irt_ctrl.sv
design/interval_reservation_table_core.sv
tb/tb_interval_reservation_table_core.sv
